FILE: design/adalight_frame_receiver_unit_assert.svh
// Assertion macros used by the frame receiver core module.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef ADALIGHT_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define ADALIGHT_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AFR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define AFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/afr_pkg.sv
// Shared types and constants of the frame receiver.
// No dependencies; imported by every module of the block.
package afr_pkg;

	localparam int unsigned LedCountW    = 16;
	localparam int unsigned HelloPeriodW = 16;
	localparam int unsigned IdleLimitW   = 24;
	localparam int unsigned CfgIndexW    = 2;
	localparam int unsigned CfgDataW     = 24;
	localparam int unsigned OutDataW     = 40;
	localparam int unsigned OutUserW     = 4;

	localparam logic [LedCountW-1:0]    LED_COUNT_RST    = 16'd60;
	localparam logic [HelloPeriodW-1:0] HELLO_PERIOD_RST = 16'd1000;
	localparam logic [IdleLimitW-1:0]   IDLE_LIMIT_RST   = 24'd60000;

	// Register indexes of the configuration port.
	localparam logic [CfgIndexW-1:0] REG_LED_COUNT    = 2'd0;
	localparam logic [CfgIndexW-1:0] REG_HELLO_PERIOD = 2'd1;
	localparam logic [CfgIndexW-1:0] REG_IDLE_LIMIT   = 2'd2;

	// Input item kinds.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [7:0] MAGIC_0    = 8'h41; // 'A'
	localparam logic [7:0] MAGIC_1    = 8'h64; // 'd'
	localparam logic [7:0] MAGIC_2    = 8'h61; // 'a'
	localparam logic [7:0] CHECK_XOR  = 8'h55;

	typedef struct packed {
		logic [LedCountW-1:0]    led_count;
		logic [HelloPeriodW-1:0] hello_period;
		logic [IdleLimitW-1:0]   idle_limit;
	} afr_cfg_t;

	typedef struct packed {
		logic        has_result;
		logic        pixel_valid;
		logic [15:0] pixel_index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        clear_strip;
		logic        show_strip;
		logic        hello;
	} afr_result_t;

endpackage

FILE: design/adalight_frame_receiver_unit.sv
// Top level of the frame receiver: configuration registers and stage wiring.
// Depends on afr_pkg, afr_in_stage, afr_core and afr_out_stage.
//
// Channel   Direction  Beat carries
// s_axis    in         tuser: opcode; tdata: data_byte
// m_axis    out        tuser: flags; tdata: pixel index and color
// cfg       in         cfg_index selects the register, cfg_data the value
//
// One beat is accepted per cycle unless m_axis stalls; m_axis is driven from a register.
// The protocol state updates as the beat leaves the input register.
// Reset clears all protocol state and loads the default register values.
// A stalled output holds its beat and backs up through the input register to s_axis.
// Beats that cause no result are consumed without reaching the output.
module adalight_frame_receiver_unit
	import afr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
	input  logic                 s_axis_tuser,  // [0] opcode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [OutDataW-1:0]  m_axis_tdata,  // [15:0] pixel_index, [23:16] red,
	                                            // [31:24] green, [39:32] blue
	output logic [OutUserW-1:0]  m_axis_tuser,  // [0] pixel_valid, [1] clear_strip,
	                                            // [2] show_strip, [3] hello
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	afr_cfg_t    cfg_q;
	afr_result_t res;
	logic        valid_s1;
	logic        opcode_s1;
	logic [7:0]  byte_s1;
	logic        out_free;
	logic        advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_count    <= LED_COUNT_RST;
			cfg_q.hello_period <= HELLO_PERIOD_RST;
			cfg_q.idle_limit   <= IDLE_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LED_COUNT:    cfg_q.led_count    <= cfg_data[LedCountW-1:0];
				REG_HELLO_PERIOD: cfg_q.hello_period <= cfg_data[HelloPeriodW-1:0];
				REG_IDLE_LIMIT:   cfg_q.idle_limit   <= cfg_data[IdleLimitW-1:0];
				default: ;
			endcase
		end
	end

	afr_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.s_opcode  (s_axis_tuser),
		.s_byte    (s_axis_tdata),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.opcode_s1 (opcode_s1),
		.byte_s1   (byte_s1)
	);

	afr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.opcode    (opcode_s1),
		.data_byte (byte_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	afr_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance && res.has_result),
		.res     (res),
		.free    (out_free),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_data  (m_axis_tdata),
		.m_user  (m_axis_tuser)
	);

endmodule

FILE: design/afr_in_stage.sv
// Input register of the frame receiver: holds one accepted beat.
// Depends on afr_pkg.
module afr_in_stage
	import afr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_valid,
	output logic       s_ready,
	input  logic       s_opcode,
	input  logic [7:0] s_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic       opcode_s1,
	output logic [7:0] byte_s1
);

	assign s_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_ready) begin
			valid_s1 <= s_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_ready && s_valid) begin
			opcode_s1 <= s_opcode;
			byte_s1   <= s_byte;
		end
	end

endmodule

FILE: design/afr_core.sv
// Protocol state of the frame receiver: header match, pixel gathering and timers.
// Depends on afr_pkg and the assertion macro header.
`include "adalight_frame_receiver_unit_assert.svh"

module afr_core
	import afr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic        opcode,
	input  logic [7:0]  data_byte,
	input  afr_cfg_t    cfg,
	output afr_result_t res
);

	typedef enum logic {
		MODE_HEADER,
		MODE_DATA
	} mode_t;

	localparam logic [2:0] HDR_M0    = 3'd0;
	localparam logic [2:0] HDR_M1    = 3'd1;
	localparam logic [2:0] HDR_M2    = 3'd2;
	localparam logic [2:0] HDR_HI    = 3'd3;
	localparam logic [2:0] HDR_LO    = 3'd4;
	localparam logic [2:0] HDR_CHECK = 3'd5;

	mode_t       mode_q, mode_d;
	logic [2:0]  pos_q, pos_d;
	logic [7:0]  hi_q, hi_d;
	logic [7:0]  lo_q, lo_d;
	logic [17:0] left_q, left_d;
	logic [16:0] pix_q, pix_d;
	logic [1:0]  phase_q, phase_d;
	logic [7:0]  red_q, red_d;
	logic [7:0]  green_q, green_d;
	logic [15:0] hello_q, hello_d;
	logic [23:0] idle_q, idle_d;

	logic [16:0] pix_count;
	logic [17:0] load_bytes;
	logic [17:0] left_dec;
	logic [15:0] hello_inc;
	logic [23:0] idle_inc;

	// Frame length is three bytes per pixel, count+1 pixels.
	assign pix_count  = {1'b0, hi_q, lo_q} + 17'd1;
	assign load_bytes = {pix_count, 1'b0} + {1'b0, pix_count};
	assign left_dec   = left_q - 18'd1;
	assign hello_inc  = (hello_q != '1) ? hello_q + 16'd1 : hello_q;
	assign idle_inc   = (idle_q != '1) ? idle_q + 24'd1 : idle_q;

	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_q;
		hi_d    = hi_q;
		lo_d    = lo_q;
		left_d  = left_q;
		pix_d   = pix_q;
		phase_d = phase_q;
		red_d   = red_q;
		green_d = green_q;
		hello_d = hello_q;
		idle_d  = idle_q;
		res     = '0;
		if (fire) begin
			if (opcode == OP_BYTE) begin
				hello_d = '0;
				idle_d  = '0;
				if (mode_q == MODE_HEADER) begin
					// A magic mismatch restarts the match without testing this byte again.
					unique case (pos_q)
						HDR_M0: pos_d = (data_byte == MAGIC_0) ? HDR_M1 : HDR_M0;
						HDR_M1: pos_d = (data_byte == MAGIC_1) ? HDR_M2 : HDR_M0;
						HDR_M2: pos_d = (data_byte == MAGIC_2) ? HDR_HI : HDR_M0;
						HDR_HI: begin
							hi_d  = data_byte;
							pos_d = HDR_LO;
						end
						HDR_LO: begin
							lo_d  = data_byte;
							pos_d = HDR_CHECK;
						end
						HDR_CHECK: begin
							if (data_byte == (hi_q ^ lo_q ^ CHECK_XOR)) begin
								left_d          = load_bytes;
								pix_d           = '0;
								phase_d         = 2'd0;
								mode_d          = MODE_DATA;
								res.clear_strip = 1'b1;
							end
							pos_d = HDR_M0;
						end
						default: pos_d = HDR_M0;
					endcase
				end else begin
					if (pix_q < {1'b0, cfg.led_count}) begin
						unique case (phase_q)
							2'd0: begin
								red_d   = data_byte;
								phase_d = 2'd1;
							end
							2'd1: begin
								green_d = data_byte;
								phase_d = 2'd2;
							end
							default: begin
								res.pixel_valid = 1'b1;
								res.pixel_index = pix_q[15:0];
								res.red         = red_q;
								res.green       = green_q;
								res.blue        = data_byte;
								phase_d         = 2'd0;
								pix_d           = pix_q + 17'd1;
							end
						endcase
					end
					left_d = left_dec;
					if (left_dec == '0) begin
						mode_d         = MODE_HEADER;
						res.show_strip = 1'b1;
					end
				end
			end else begin
				hello_d = hello_inc;
				idle_d  = idle_inc;
				if (hello_inc >= cfg.hello_period) begin
					res.hello = 1'b1;
					hello_d   = '0;
					// Idle blanking leaves the header match position alone.
					if (idle_inc >= cfg.idle_limit) begin
						res.clear_strip = 1'b1;
						res.show_strip  = 1'b1;
						mode_d          = MODE_HEADER;
						idle_d          = '0;
					end
				end
			end
		end
		res.has_result = res.pixel_valid || res.clear_strip || res.show_strip || res.hello;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HEADER;
			pos_q   <= HDR_M0;
			hi_q    <= '0;
			lo_q    <= '0;
			left_q  <= '0;
			pix_q   <= '0;
			phase_q <= 2'd0;
			red_q   <= '0;
			green_q <= '0;
			hello_q <= '0;
			idle_q  <= '0;
		end else begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			hi_q    <= hi_d;
			lo_q    <= lo_d;
			left_q  <= left_d;
			pix_q   <= pix_d;
			phase_q <= phase_d;
			red_q   <= red_d;
			green_q <= green_d;
			hello_q <= hello_d;
			idle_q  <= idle_d;
		end
	end

	`AFR_ASSERT_NOW(a_pos_range, 1'b1, pos_q <= HDR_CHECK, "header position out of range")
	`AFR_ASSERT_NOW(a_data_left, mode_q == MODE_DATA, left_q != '0, "data mode with no bytes left")
	`AFR_ASSERT_NOW(a_phase_range, 1'b1, phase_q != 2'd3, "channel phase out of range")
	`AFR_ASSERT_NOW(a_pixel_no_hello, res.pixel_valid, !res.hello, "pixel and hello in one result")
	`AFR_ASSERT_NEXT(a_byte_clears, fire && opcode == OP_BYTE, hello_q == '0 && idle_q == '0,
		"timers not cleared by a byte")

endmodule

FILE: design/afr_out_stage.sv
// Result register of the frame receiver, packed onto the master stream.
// Depends on afr_pkg.
module afr_out_stage
	import afr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  afr_result_t         res,
	output logic                free,
	output logic                m_valid,
	input  logic                m_ready,
	output logic [OutDataW-1:0] m_data,
	output logic [OutUserW-1:0] m_user
);

	afr_result_t res_s2;

	assign free = !m_valid || m_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid <= 1'b0;
		end else if (free) begin
			m_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_s2 <= res;
		end
	end

	assign m_data = {res_s2.blue, res_s2.green, res_s2.red, res_s2.pixel_index};
	assign m_user = {res_s2.hello, res_s2.show_strip, res_s2.clear_strip, res_s2.pixel_valid};

endmodule
